@@ src/ucpd_pkg.sv @@
// shared types and constants for the utf-8 code point decoder
// no dependencies; imported by every module of the block
package ucpd_pkg;

   localparam int CodePointW = 21;
   localparam int ByteW      = 8;
   localparam int RepCountW  = 2;

   localparam logic [CodePointW-1:0] ReplacementChar = 21'h00FFFD;

   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // work for the back end: some replacement words, then an optional final word
   typedef struct packed {
      logic [RepCountW-1:0]  rep_count;
      logic                  has_final;
      logic [CodePointW-1:0] final_cp;
      logic                  final_bad;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ src/utf8_code_point_decoder_unit.sv @@
// utf-8 decoder: one text byte in per cycle unless full, code points out via a job queue
// an accepted byte's job is queued, then loaded into the back end's output register
// throughput: one byte per cycle while each yields at most one word and pop stays high;
//   a byte flushing held bytes gives one word per held byte, plus its own word if any
// reset (synchronous) closes any open sequence and empties the job queue and back end
module utf8_code_point_decoder_unit
   import ucpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [ByteW-1:0]      req_text_byte,
   output logic                  empty,
   input  logic                  pop,
   output logic [CodePointW-1:0] rsp_code_point,
   output logic                  rsp_malformed,
   output logic                  rsp_last_of_run
);

   queue_status_type q_status;
   job_type          front_job, q_job;
   logic             job_push, q_pop;

   assign full = q_status.full;

   ucpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (push),
      .text_byte  (req_text_byte),
      .q_status   (q_status),
      .job_push   (job_push),
      .job        (front_job)
   );

   ucpd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (job_push),
      .wr_job (front_job),
      .rd_en  (q_pop),
      .rd_job (q_job),
      .status (q_status)
   );

   ucpd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_job       (q_job),
      .q_status    (q_status),
      .q_pop       (q_pop),
      .empty       (empty),
      .pop         (pop),
      .code_point  (rsp_code_point),
      .malformed   (rsp_malformed),
      .last_of_run (rsp_last_of_run)
   );

endmodule

@@ src/ucpd_front.sv @@
// front end: takes text bytes, tracks the open sequence, emits at most one job per byte
// depends on ucpd_pkg
module ucpd_front
   import ucpd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_valid,
   input  logic [ByteW-1:0] text_byte,
   input  queue_status_type q_status,
   output logic             job_push,
   output job_type          job
);

   logic [CodePointW-1:0] partial_value_ff, partial_value_in;
   logic [1:0]            bytes_expected_ff, bytes_expected_in;
   logic [1:0]            bytes_held_ff, bytes_held_in;

   logic                  take;
   logic                  is_cont;
   logic [CodePointW-1:0] shifted;
   job_type               job_c;

   assign take     = byte_valid && !q_status.full;
   assign is_cont  = (text_byte[7:6] == 2'b10);
   assign shifted  = {partial_value_ff[CodePointW-7:0], text_byte[5:0]};

   always_comb begin
      partial_value_in  = partial_value_ff;
      bytes_expected_in = bytes_expected_ff;
      bytes_held_in     = bytes_held_ff;
      job_c.rep_count   = '0;
      job_c.has_final   = 1'b0;
      job_c.final_cp    = ReplacementChar;
      job_c.final_bad   = 1'b1;
      if (bytes_expected_ff != 2'd0 && is_cont) begin
         if (bytes_expected_ff == 2'd1) begin
            job_c.has_final   = 1'b1;
            job_c.final_cp    = shifted;
            job_c.final_bad   = 1'b0;
            partial_value_in  = '0;
            bytes_expected_in = 2'd0;
            bytes_held_in     = 2'd0;
         end else begin
            partial_value_in  = shifted;
            bytes_expected_in = bytes_expected_ff - 2'd1;
            bytes_held_in     = bytes_held_ff + 2'd1;
         end
      end else begin
         // flush held bytes of a broken sequence, if any; then the byte decodes fresh
         job_c.rep_count   = (bytes_expected_ff != 2'd0) ? bytes_held_ff : 2'd0;
         partial_value_in  = '0;
         bytes_expected_in = 2'd0;
         bytes_held_in     = 2'd0;
         if (text_byte == '0) begin
            job_c.has_final = 1'b0;
         end else if (!text_byte[7]) begin
            job_c.has_final = 1'b1;
            job_c.final_cp  = {{(CodePointW-ByteW){1'b0}}, text_byte};
            job_c.final_bad = 1'b0;
         end else if (text_byte[7:5] == 3'b110) begin
            partial_value_in  = {{(CodePointW-5){1'b0}}, text_byte[4:0]};
            bytes_expected_in = 2'd1;
            bytes_held_in     = 2'd1;
         end else if (text_byte[7:4] == 4'b1110) begin
            partial_value_in  = {{(CodePointW-4){1'b0}}, text_byte[3:0]};
            bytes_expected_in = 2'd2;
            bytes_held_in     = 2'd1;
         end else if (text_byte[7:3] == 5'b11110) begin
            partial_value_in  = {{(CodePointW-3){1'b0}}, text_byte[2:0]};
            bytes_expected_in = 2'd3;
            bytes_held_in     = 2'd1;
         end else begin
            job_c.has_final = 1'b1;
         end
      end
   end

   assign job      = job_c;
   assign job_push = take && (job_c.has_final || job_c.rep_count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_value_ff  <= '0;
         bytes_expected_ff <= 2'd0;
         bytes_held_ff     <= 2'd0;
      end else if (take) begin
         partial_value_ff  <= partial_value_in;
         bytes_expected_ff <= bytes_expected_in;
         bytes_held_ff     <= bytes_held_in;
      end
   end

   // no open sequence means nothing held
   assert property (@(posedge clock) disable iff (reset)
      bytes_expected_ff == 2'd0 |-> bytes_held_ff == 2'd0 && partial_value_ff == '0)
      else $error("held bytes with no open sequence");

endmodule

@@ src/ucpd_queue.sv @@
// short job queue between front and back end, flip-flop storage
// depends on ucpd_pkg
module ucpd_queue
   import ucpd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  job_type          wr_job,
   input  logic             rd_en,
   output job_type          rd_job,
   output queue_status_type status
);

   job_type                entry_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QueueCntW-1:0]   count_ff, count_in;

   assign status.full  = (count_ff == QueueCntW'(QueueDepth));
   assign status.empty = (count_ff == '0);
   assign rd_job       = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (rd_en) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(wr_en && status.full))
      else $error("write into full job queue");

   assert property (@(posedge clock) disable iff (reset) !(rd_en && status.empty))
      else $error("read from empty job queue");

endmodule

@@ src/ucpd_back.sv @@
// back end: expands each job into result words, one word per cycle while popped
// depends on ucpd_pkg
module ucpd_back
   import ucpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  job_type               q_job,
   input  queue_status_type      q_status,
   output logic                  q_pop,
   output logic                  empty,
   input  logic                  pop,
   output logic [CodePointW-1:0] code_point,
   output logic                  malformed,
   output logic                  last_of_run
);

   logic                  valid_ff;
   logic [RepCountW-1:0]  rep_left_ff;
   logic                  has_final_ff;
   logic [CodePointW-1:0] final_cp_ff;
   logic                  final_bad_ff;

   logic cur_last;
   logic slot_free;

   assign cur_last  = (rep_left_ff == '0) || (rep_left_ff == RepCountW'(1) && !has_final_ff);
   assign slot_free = !valid_ff || (pop && cur_last);
   assign q_pop     = slot_free && !q_status.empty;

   assign empty       = !valid_ff;
   assign code_point  = (rep_left_ff != '0) ? ReplacementChar : final_cp_ff;
   assign malformed   = (rep_left_ff != '0) ? 1'b1 : final_bad_ff;
   assign last_of_run = cur_last;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         has_final_ff <= q_job.has_final;
         final_cp_ff  <= q_job.final_cp;
         final_bad_ff <= q_job.final_bad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         rep_left_ff <= '0;
      end else if (q_pop) begin
         valid_ff    <= 1'b1;
         rep_left_ff <= q_job.rep_count;
      end else if (pop && valid_ff) begin
         if (cur_last) begin
            valid_ff <= 1'b0;
         end else begin
            rep_left_ff <= rep_left_ff - 1'b1;
         end
      end
   end

   // every malformed word shown is the replacement character
   assert property (@(posedge clock) disable iff (reset)
      !empty && malformed |-> code_point == ReplacementChar)
      else $error("malformed word without replacement character");

   // popping a word that is not the last of its job leaves the block non-empty
   assert property (@(posedge clock) disable iff (reset)
      !empty && pop && !cur_last |=> !empty)
      else $error("job dropped before its last word");

endmodule

@@ tb/sv/ucpd_scoreboard_pkg.sv @@
// scoreboard for the utf-8 code point decoder: predicts the words each text byte causes
// and checks the words popped from the block; depends on ucpd_pkg for widths and constants
`timescale 1ns / 1ps

package ucpd_scoreboard_pkg;
   import ucpd_pkg::*;

   typedef struct {
      logic [CodePointW-1:0] code_point;
      logic                  malformed;
      logic                  last_of_run;
   } decoded_word_type;

   class ucpd_scoreboard;
      // decoder state as seen by the predictor
      logic [CodePointW-1:0] seq_value;
      logic [1:0]            seq_left;
      logic [1:0]            seq_held;

      decoded_word_type run_words[$];
      decoded_word_type expected_words[$];
      int                    mismatches;

      function new();
         clear_sequence();
         mismatches = 0;
      endfunction

      function void clear_sequence();
         seq_value = '0;
         seq_left  = '0;
         seq_held  = '0;
      endfunction

      function void add_word(logic [CodePointW-1:0] cp, logic bad);
         decoded_word_type w;
         w.code_point  = cp;
         w.malformed   = bad;
         w.last_of_run = 1'b0;
         run_words.push_back(w);
      endfunction

      // byte seen with no sequence open
      function void decode_fresh(logic [ByteW-1:0] b);
         if (b == '0) begin
            return;
         end
         casez (b)
            8'b0???????: begin
               add_word({13'b0, b}, 1'b0);
            end
            8'b110?????: begin
               seq_value = {16'b0, b[4:0]};
               seq_left  = 2'd1;
               seq_held  = 2'd1;
            end
            8'b1110????: begin
               seq_value = {17'b0, b[3:0]};
               seq_left  = 2'd2;
               seq_held  = 2'd1;
            end
            8'b11110???: begin
               seq_value = {18'b0, b[2:0]};
               seq_left  = 2'd3;
               seq_held  = 2'd1;
            end
            // stray continuation or invalid lead
            default: add_word(ReplacementChar, 1'b1);
         endcase
      endfunction

      function void note_byte(logic [ByteW-1:0] b);
         run_words.delete();
         if (seq_left != 0) begin
            if (b[7:6] == 2'b10) begin
               seq_value = {seq_value[CodePointW-7:0], b[5:0]};
               seq_held  = seq_held + 2'd1;
               seq_left  = seq_left - 2'd1;
               if (seq_left == 0) begin
                  add_word(seq_value, 1'b0);
                  clear_sequence();
               end
            end else begin
               // missing continuation: one replacement per held byte, then decode afresh
               repeat (seq_held) add_word(ReplacementChar, 1'b1);
               clear_sequence();
               decode_fresh(b);
            end
         end else begin
            decode_fresh(b);
         end
         if (run_words.size() > 0) begin
            run_words[run_words.size()-1].last_of_run = 1'b1;
         end
         foreach (run_words[i]) expected_words.push_back(run_words[i]);
      endfunction

      function void check_word(logic [CodePointW-1:0] cp, logic bad, logic last);
         decoded_word_type w;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected word: cp %h malformed %b last %b", cp, bad, last);
            end
            return;
         end
         w = expected_words.pop_front();
         if (cp !== w.code_point || bad !== w.malformed || last !== w.last_of_run) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display({"word mismatch: expected cp %h malformed %b last %b,",
                         " got cp %h malformed %b last %b"},
                        w.code_point, w.malformed, w.last_of_run, cp, bad, last);
            end
         end
      endfunction

      function int words_outstanding();
         return expected_words.size();
      endfunction

      // words predicted but never popped count as failures
      function void close_out();
         if (expected_words.size() > 0) begin
            $display("%0d expected words never arrived", expected_words.size());
            mismatches += expected_words.size();
            expected_words.delete();
         end
      endfunction
   endclass

endpackage

@@ tb/sv/tb.sv @@
// top of the testbench for utf8_code_point_decoder_unit: drives text bytes and pops words
// with random idling, checks each word against ucpd_scoreboard; needs ucpd_pkg and the scoreboard
`timescale 1ns / 1ps

module tb;
   import ucpd_pkg::*;
   import ucpd_scoreboard_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   logic [ByteW-1:0]      req_text_byte = '0;
   logic                  empty;
   logic                  pop = 1'b0;
   logic [CodePointW-1:0] rsp_code_point;
   logic                  rsp_malformed;
   logic                  rsp_last_of_run;

   ucpd_scoreboard sb = new();

   int  bytes_sent = 0;
   bit  tx_idle = 1'b1;
   bit  tx_done = 1'b0;

   utf8_code_point_decoder_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_text_byte   (req_text_byte),
      .empty           (empty),
      .pop             (pop),
      .rsp_code_point  (rsp_code_point),
      .rsp_malformed   (rsp_malformed),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always #5 clock = ~clock;

   initial begin
      #5ms;
      $display("TB_ERROR");
      $finish;
   end

   task automatic send_byte(input logic [ByteW-1:0] b);
      int gap;
      gap = tx_idle ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push          <= 1'b1;
      req_text_byte <= b;
      @(posedge clock);
      while (full) @(posedge clock);
      sb.note_byte(b);
      bytes_sent++;
      if (bytes_sent % 20 == 0) begin
         tx_idle = ($urandom_range(0, 2) != 0);
      end
   endtask

   function automatic logic [ByteW-1:0] cont_byte(logic [5:0] bits);
      return {2'b10, bits};
   endfunction

   // well-formed sequence of 1 to 4 bytes with random payload
   task automatic send_good_char();
      int          len;
      logic [31:0] v;
      len = $urandom_range(1, 4);
      v   = $urandom;
      case (len)
         1: begin
            send_byte({1'b0, v[6:0]});
         end
         2: begin
            send_byte({3'b110, v[10:6]});
            send_byte(cont_byte(v[5:0]));
         end
         3: begin
            send_byte({4'b1110, v[15:12]});
            send_byte(cont_byte(v[11:6]));
            send_byte(cont_byte(v[5:0]));
         end
         default: begin
            send_byte({5'b11110, v[20:18]});
            send_byte(cont_byte(v[17:12]));
            send_byte(cont_byte(v[11:6]));
            send_byte(cont_byte(v[5:0]));
         end
      endcase
   endtask

   // lead byte, too few continuations, then a byte that is not a continuation
   task automatic send_broken_char();
      int          len;
      int          conts;
      logic [31:0] v;
      logic [7:0]  breaker;
      len   = $urandom_range(2, 4);
      conts = $urandom_range(0, len - 2);
      v     = $urandom;
      case (len)
         2:       send_byte({3'b110, v[4:0]});
         3:       send_byte({4'b1110, v[3:0]});
         default: send_byte({5'b11110, v[2:0]});
      endcase
      repeat (conts) send_byte(cont_byte(6'($urandom)));
      case ($urandom_range(0, 4))
         0:       breaker = {1'b0, 7'($urandom)};
         1:       breaker = 8'h00;
         2:       breaker = {2'b11, 6'($urandom)};
         3:       breaker = {5'b11111, 3'($urandom)};
         default: breaker = {1'b0, 7'($urandom)};
      endcase
      send_byte(breaker);
   endtask

   initial begin
      logic [ByteW-1:0] directed[$];
      int               r;
      directed = '{8'h7F, 8'hC2, 8'hA9, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
                   8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h80, 8'hF8, 8'hFF,
                   8'hE2, 8'h82, 8'h41, 8'hF0, 8'h90, 8'h80, 8'hC0,
                   8'h00, 8'h00, 8'h01};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_byte(directed[i]);
      while (bytes_sent < 180) begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            send_good_char();
         end else if (r < 85) begin
            send_broken_char();
         end else if (r < 92) begin
            send_byte(8'($urandom_range(0, 255)));
         end else begin
            send_byte(8'h00);
         end
      end
      push <= 1'b0;
      tx_done = 1'b1;
   end

   // receiver: random pop idling, one long hold-off to fill the block
   initial begin
      int words_seen;
      int gap;
      bit rx_idle;
      bit held_off;
      words_seen = 0;
      rx_idle    = 1'b1;
      held_off   = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         gap = rx_idle ? $urandom_range(0, 10) : 0;
         if (words_seen == 30 && !held_off) begin
            held_off = 1'b1;
            gap      = 300;
         end
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         sb.check_word(rsp_code_point, rsp_malformed, rsp_last_of_run);
         words_seen++;
         if (words_seen % 25 == 0) begin
            rx_idle = ($urandom_range(0, 2) != 0);
         end
      end
   end

   initial begin
      int waited;
      waited = 0;
      @(posedge clock);
      while (!tx_done) @(posedge clock);
      while (sb.words_outstanding() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      // let any stray word show up
      repeat (20) @(posedge clock);
      sb.close_out();
      if (sb.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/ucpd_pkg.sv
src/ucpd_front.sv
src/ucpd_queue.sv
src/ucpd_back.sv
src/utf8_code_point_decoder_unit.sv
tb/sv/ucpd_scoreboard_pkg.sv
tb/sv/tb.sv
